// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = PROD_W + 1;
  localparam int NUM_W      = PROD_W + FRAC_BITS;
  localparam int QUO_W      = DATA_WIDTH + 1;
  localparam int REM_W      = PROD_W;
  localparam int CMP_W      = REM_W + QUO_W;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic                  ovf;
    logic [DATA_WIDTH-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] rest;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             big;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             dz;
    logic [REM_W-1:0] den;
    lane_t            re;
    lane_t            im;
    sat_t             dir_re;
    sat_t             dir_im;
  } cell_t;

  function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_WIDTH:0] hi;
    sat_t                      s;
    hi = v[SUM_W-1:DATA_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      s.ovf = 1'b0;
      s.val = v[DATA_WIDTH-1:0];
    end else begin
      s.ovf = 1'b1;
      s.val = v[SUM_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// A transaction is accepted at a rising edge where start is high and busy is
// low; busy is only high while reset is applied, so one transaction may be
// issued every cycle. The operation code and both complex operands are
// sampled at that edge.
// Every transaction produces exactly one result, presented on res_re, res_im,
// overflow and div_zero for one cycle while done is high. All operations
// take the same path: a multiplier stage, a sum stage, a divide set-up
// stage, a row of 33 restoring-division cells (one quotient bit each, for
// both parts at once) and an output register. Throughput is one
// transaction per cycle regardless of the operation. Parts outside the
// 32-bit range saturate and raise overflow; a divide by a zero divisor
// gives zero parts with div_zero set. The receiver cannot stall: done is
// a one-cycle strobe and results must be taken when shown. Synchronous
// reset empties the pipeline, so no result follows reset until new
// transactions are accepted.
module complex_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            op,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
  output logic                                  done,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
  output logic                                  overflow,
  output logic                                  div_zero
);

  localparam int EXT_W = cau_pkg::QUO_W + 2;

  cau_pkg::cell_t chain [cau_pkg::QUO_W+1];
  cau_pkg::cell_t last;
  cau_pkg::sat_t  fin_re, fin_im;
  logic           dz_next;

  assign busy = rst;

  cau_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .op       (op),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .out      (chain[0])
  );

  for (genvar g = 0; g < cau_pkg::QUO_W; g++) begin : g_cell
    cau_cell u_cell (
      .clk (clk),
      .rst (rst),
      .in  (chain[g]),
      .out (chain[g+1])
    );
  end

  assign last = chain[cau_pkg::QUO_W];

  function automatic cau_pkg::sat_t div_result(input cau_pkg::lane_t l);
    logic signed [EXT_W-1:0] q;
    cau_pkg::sat_t           s;
    q = {2'b00, l.quo};
    if (l.neg) begin
      q = -q;
    end
    if (l.big) begin
      s.ovf = 1'b1;
      s.val = l.neg ? {1'b1, {(cau_pkg::DATA_WIDTH-1){1'b0}}}
                    : {1'b0, {(cau_pkg::DATA_WIDTH-1){1'b1}}};
    end else begin
      s = cau_pkg::saturate(cau_pkg::SUM_W'(q));
    end
    return s;
  endfunction

  always_comb begin
    dz_next = last.is_div && last.dz;
    if (!last.is_div) begin
      fin_re = last.dir_re;
      fin_im = last.dir_im;
    end else if (last.dz) begin
      fin_re = '0;
      fin_im = '0;
    end else begin
      fin_re = div_result(last.re);
      fin_im = div_result(last.im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      overflow <= 1'b0;
      div_zero <= 1'b0;
    end else begin
      done     <= last.valid;
      overflow <= last.valid && (fin_re.ovf || fin_im.ovf);
      div_zero <= last.valid && dz_next;
    end
    res_re <= fin_re.val;
    res_im <= fin_im.val;
  end

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    div_zero |-> (res_re == '0 && res_im == '0 && !overflow))
    else $error("divide by zero result is not clean");

  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!overflow && !div_zero))
    else $error("flag raised without a result");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result presented straight after reset");

endmodule

// ===== hw/rtl/cau_prep.sv =====
module cau_prep (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [1:0]                             op,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im,
  output cau_pkg::cell_t                         out
);

  logic                                  v1, v2;
  cau_pkg::op_t                          op1, op2;
  logic signed [cau_pkg::PROD_W-1:0]     p_rr, p_ii, p_ri, p_ir, s_rr, s_ii;
  logic signed [cau_pkg::DATA_WIDTH:0]   as_re1, as_im1, as_re2, as_im2;
  logic signed [cau_pkg::SUM_W-1:0]      m_re, m_im, n_re, n_im;
  logic [cau_pkg::REM_W-1:0]             den;
  logic signed [cau_pkg::SUM_W-1:0]      sh_re, sh_im;
  cau_pkg::cell_t                        out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out.valid <= v2;
    end
    op1  <= cau_pkg::op_t'(op);
    p_rr <= a_re * b_re;
    p_ii <= a_im * b_im;
    p_ri <= a_re * b_im;
    p_ir <= a_im * b_re;
    s_rr <= b_re * b_re;
    s_ii <= b_im * b_im;
    if (cau_pkg::op_t'(op) == cau_pkg::OP_SUB) begin
      as_re1 <= (cau_pkg::DATA_WIDTH+1)'(a_re) - (cau_pkg::DATA_WIDTH+1)'(b_re);
      as_im1 <= (cau_pkg::DATA_WIDTH+1)'(a_im) - (cau_pkg::DATA_WIDTH+1)'(b_im);
    end else begin
      as_re1 <= (cau_pkg::DATA_WIDTH+1)'(a_re) + (cau_pkg::DATA_WIDTH+1)'(b_re);
      as_im1 <= (cau_pkg::DATA_WIDTH+1)'(a_im) + (cau_pkg::DATA_WIDTH+1)'(b_im);
    end
    op2    <= op1;
    as_re2 <= as_re1;
    as_im2 <= as_im1;
    m_re   <= cau_pkg::SUM_W'(p_rr) - cau_pkg::SUM_W'(p_ii);
    m_im   <= cau_pkg::SUM_W'(p_ri) + cau_pkg::SUM_W'(p_ir);
    n_re   <= cau_pkg::SUM_W'(p_rr) + cau_pkg::SUM_W'(p_ii);
    n_im   <= cau_pkg::SUM_W'(p_ir) - cau_pkg::SUM_W'(p_ri);
    den    <= cau_pkg::REM_W'(s_rr) + cau_pkg::REM_W'(s_ii);
    out.is_div <= out_next.is_div;
    out.dz     <= out_next.dz;
    out.den    <= out_next.den;
    out.re     <= out_next.re;
    out.im     <= out_next.im;
    out.dir_re <= out_next.dir_re;
    out.dir_im <= out_next.dir_im;
  end

  function automatic cau_pkg::lane_t lane_init(input logic signed [cau_pkg::SUM_W-1:0] n,
                                               input logic [cau_pkg::REM_W-1:0] d);
    logic [cau_pkg::SUM_W-1:0] mag;
    logic [cau_pkg::NUM_W-1:0] num;
    logic [cau_pkg::CMP_W-1:0] lhs, rhs;
    cau_pkg::lane_t            l;
    mag  = n[cau_pkg::SUM_W-1] ? -n : n;
    num  = {mag[cau_pkg::PROD_W-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
    lhs  = {{(cau_pkg::CMP_W-cau_pkg::NUM_W){1'b0}}, num};
    rhs  = {d, {cau_pkg::QUO_W{1'b0}}};
    l.neg  = n[cau_pkg::SUM_W-1];
    l.big  = (lhs >= rhs);
    l.rem  = {{(cau_pkg::REM_W-(cau_pkg::NUM_W-cau_pkg::QUO_W)){1'b0}},
              num[cau_pkg::NUM_W-1:cau_pkg::QUO_W]};
    l.rest = num[cau_pkg::QUO_W-1:0];
    l.quo  = '0;
    return l;
  endfunction

  always_comb begin
    sh_re = m_re >>> cau_pkg::FRAC_BITS;
    sh_im = m_im >>> cau_pkg::FRAC_BITS;
    out_next        = '0;
    out_next.is_div = (op2 == cau_pkg::OP_DIV);
    out_next.dz     = (den == '0);
    out_next.den    = den;
    out_next.re     = lane_init(n_re, den);
    out_next.im     = lane_init(n_im, den);
    if (op2 == cau_pkg::OP_MUL) begin
      out_next.dir_re = cau_pkg::saturate(sh_re);
      out_next.dir_im = cau_pkg::saturate(sh_im);
    end else begin
      out_next.dir_re = cau_pkg::saturate(cau_pkg::SUM_W'(as_re2));
      out_next.dir_im = cau_pkg::saturate(cau_pkg::SUM_W'(as_im2));
    end
  end

endmodule

// ===== hw/rtl/cau_cell.sv =====
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::cell_t in,
  output cau_pkg::cell_t out
);

  cau_pkg::cell_t out_next;

  function automatic cau_pkg::lane_t lane_step(input cau_pkg::lane_t l,
                                               input logic [cau_pkg::REM_W-1:0] d);
    logic [cau_pkg::REM_W:0] t, diff;
    logic                    ge;
    cau_pkg::lane_t          r;
    t    = {l.rem, l.rest[cau_pkg::QUO_W-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    r       = l;
    r.rem   = ge ? diff[cau_pkg::REM_W-1:0] : t[cau_pkg::REM_W-1:0];
    r.rest  = {l.rest[cau_pkg::QUO_W-2:0], 1'b0};
    r.quo   = {l.quo[cau_pkg::QUO_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    out_next    = in;
    out_next.re = lane_step(in.re, in.den);
    out_next.im = lane_step(in.im, in.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.is_div <= out_next.is_div;
    out.dz     <= out_next.dz;
    out.den    <= out_next.den;
    out.re     <= out_next.re;
    out.im     <= out_next.im;
    out.dir_re <= out_next.dir_re;
    out.dir_im <= out_next.dir_im;
  end

endmodule

// ===== dv/complex_arithmetic_unit_tb.sv =====
module complex_arithmetic_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = cau_pkg::DATA_WIDTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_RANDOM = 1225;

  typedef struct {
    cau_pkg::op_t        op;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
  } cx_cmd_t;

  typedef struct {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                ovf;
    logic                dz;
  } cx_res_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] op;
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  logic done;
  logic signed [W-1:0] res_re, res_im;
  logic overflow, div_zero;

  cx_cmd_t cmd_queue[$];
  cx_res_t expected_results[$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned checked;
  int unsigned idle_cycles;
  int unsigned op_count[4];
  int unsigned ovf_seen;
  int unsigned dz_seen;
  int unsigned burst_left;
  int unsigned gap_left;
  bit hold_off;
  bit paused;
  bit stim_done;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im),
    .overflow(overflow), .div_zero(div_zero)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
                                                inout logic ovf);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (W - 1)) - 1;
    lo_lim = -(128'sd1 <<< (W - 1));
    if (v > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[W-1:0];
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic cx_res_t complex_result(input cx_cmd_t c);
    logic signed [127:0] ar, ai, br, bi, re, im, den, nr, ni;
    cx_res_t r;
    ar = c.a_re;
    ai = c.a_im;
    br = c.b_re;
    bi = c.b_im;
    r.ovf = 1'b0;
    r.dz = 1'b0;
    case (c.op)
      cau_pkg::OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
        im = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          nr = (ar * br + ai * bi) <<< cau_pkg::FRAC_BITS;
          ni = (ai * br - ar * bi) <<< cau_pkg::FRAC_BITS;
          re = nr / den;
          im = ni / den;
        end
      end
    endcase
    r.re = clamp(re, r.ovf);
    r.im = clamp(im, r.ovf);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic logic [W-1:0] operand_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return 32'(signed'($urandom_range(0, 16'hFFFF)) - 32'sd32768);
      5: return 32'(signed'($urandom_range(0, 24'hFFFFFF)) - 32'sd8388608) <<< 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic cx_cmd_t make_cmd(input cau_pkg::op_t o, input logic [W-1:0] x0,
                                       input logic [W-1:0] x1, input logic [W-1:0] y0,
                                       input logic [W-1:0] y1);
    cx_cmd_t c;
    c.op = o;
    c.a_re = x0;
    c.a_im = x1;
    c.b_re = y0;
    c.b_im = y1;
    return c;
  endfunction

  initial begin
    cx_cmd_t c;
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    for (int o = 0; o < 4; o++) begin
      cmd_queue.push_back(make_cmd(cau_pkg::op_t'(o), mx, mx, mx, mx));
      cmd_queue.push_back(make_cmd(cau_pkg::op_t'(o), mn, mn, mn, mn));
      cmd_queue.push_back(make_cmd(cau_pkg::op_t'(o), mx, mn, mn, mx));
      cmd_queue.push_back(make_cmd(cau_pkg::op_t'(o), 32'h0001_0000, 32'h0002_0000,
                                   32'h0003_0000, 32'hFFFF_0000));
      cmd_queue.push_back(make_cmd(cau_pkg::op_t'(o), '1, '1, 32'd1, '0));
    end
    cmd_queue.push_back(make_cmd(cau_pkg::OP_DIV, 32'h0005_0000, mn, '0, '0));
    cmd_queue.push_back(make_cmd(cau_pkg::OP_DIV, mx, mx, 32'd1, '0));
    cmd_queue.push_back(make_cmd(cau_pkg::OP_DIV, mn, '0, '1, '0));
    cmd_queue.push_back(make_cmd(cau_pkg::OP_MUL, '1, '0, '1, '0));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      c.op = cau_pkg::op_t'($urandom_range(0, 3));
      c.a_re = operand_value();
      c.a_im = operand_value();
      c.b_re = operand_value();
      c.b_im = operand_value();
      if (c.op == cau_pkg::OP_DIV && $urandom_range(0, 19) == 0) begin
        c.b_re = '0;
        c.b_im = '0;
      end
      cmd_queue.push_back(c);
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = '0;
    a_re = '0;
    a_im = '0;
    b_re = '0;
    b_im = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(negedge clk) begin
    cx_cmd_t c;
    if (rst) begin
      burst_left <= 0;
      gap_left <= 0;
      hold_off <= 1'b0;
      paused <= 1'b0;
      stim_done <= 1'b0;
    end else if (start && busy) begin
    end else if (hold_off) begin
      if (expected_results.size() == 0) hold_off <= 1'b0;
      start <= 1'b0;
    end else if (cmd_queue.size() == 0) begin
      start <= 1'b0;
      stim_done <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      c = cmd_queue.pop_front();
      start <= 1'b1;
      op <= c.op;
      a_re <= c.a_re;
      a_im <= c.a_im;
      b_re <= c.b_re;
      b_im <= c.b_im;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (!paused && cmd_queue.size() <= 600) begin
          hold_off <= 1'b1;
          paused <= 1'b1;
        end
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cx_cmd_t c;
    cx_res_t want;
    if (!rst) begin
      if (start && !busy) begin
        c.op = cau_pkg::op_t'(op);
        c.a_re = a_re;
        c.a_im = a_im;
        c.b_re = b_re;
        c.b_im = b_im;
        want = complex_result(c);
        expected_results.push_back(want);
        accepted++;
        op_count[op]++;
        if (want.ovf) ovf_seen++;
        if (want.dz) dz_seen++;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_re, '0);
        end else begin
          want = expected_results.pop_front();
          if (res_re !== want.re) report_mismatch("res_re", res_re, want.re);
          if (res_im !== want.im) report_mismatch("res_im", res_im, want.im);
          if (overflow !== want.ovf) begin
            report_mismatch("overflow", W'(overflow), W'(want.ovf));
          end
          if (div_zero !== want.dz) begin
            report_mismatch("div_zero", W'(div_zero), W'(want.dz));
          end
        end
        checked++;
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    accepted = 0;
    checked = 0;
    idle_cycles = 0;
    ovf_seen = 0;
    dz_seen = 0;
    op_count = '{default: 0};
    @(negedge rst);
    while (!(stim_done && expected_results.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("complex_arithmetic_unit_tb: FAIL");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d transactions (add %0d, sub %0d, mul %0d, div %0d).",
             checked, accepted, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("Saturated results: %0d, zero divisors: %0d, mismatches: %0d.",
             ovf_seen, dz_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("complex_arithmetic_unit_tb: PASS");
    end else begin
      $display("complex_arithmetic_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== complex_arithmetic_unit.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_prep.sv
hw/rtl/cau_cell.sv
hw/rtl/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_tb.sv
